// ----- rtl/acd_pkg.sv -----
// Shared types and constants for the ASCII command decoder.
package acd_pkg;

	// Command picked by the first byte of a datagram
	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_L    = 2'd1,
		CLS_D    = 2'd2,
		CLS_K    = 2'd3
	} cmd_class_t;

	// Shift request seen in the second byte of an 'L' command
	typedef enum logic [1:0] {
		SHIFT_NONE  = 2'd0,
		SHIFT_RIGHT = 2'd1,
		SHIFT_LEFT  = 2'd2
	} shift_kind_t;

	// Decoded action reported with each result
	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_TOGGLE   = 3'd1,
		ACT_SHR      = 3'd2,
		ACT_SHL      = 3'd3,
		ACT_INTERVAL = 3'd4,
		ACT_KEY      = 3'd5
	} action_t;

	localparam int unsigned ACC_W = 31;
	localparam int unsigned KEY_W = 128;

	localparam logic [ACC_W-1:0] ACC_MAX        = 31'h7FFF_FFFF;
	localparam logic [ACC_W-1:0] LED_MAX        = 31'd15;
	localparam logic [ACC_W-1:0] RESET_INTERVAL = 31'd500;
	localparam int unsigned      KEY_CHARS      = 32;
	localparam int unsigned      KEY_MIN_LEN    = 33;

	localparam logic [KEY_W-1:0] RESET_KEY =
		128'h2B7E151628AED2A6_ABF7158809CF4F3C;

	// One result beat
	typedef struct packed {
		action_t          action;
		logic [3:0]       led_number;
		logic [ACC_W-1:0] interval_ms;
		logic [KEY_W-1:0] key;
	} result_t;

endpackage

// ----- rtl/ascii_command_decoder_top.sv -----
// Top level of the ASCII command decoder: input stage, parser and result register.
// Decodes one command datagram byte per beat; the beat carrying last yields one
// result with the action, LED number, current interval and current 128-bit key.
// A byte is registered in the input stage on acceptance and parsed from there, so
// the block takes one byte every cycle unless the input stalls; a result is offered
// from the result register once its last byte is parsed. Input stalls only while a
// finished result is held in the output register by a receiver stall and the next
// last byte needs that register.
module ascii_command_decoder_top #(
	parameter int unsigned MAX_DATAGRAM_BYTES = 99
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [3:0]  led_number,
	output logic [30:0] interval_ms,
	output logic [63:0] key_high,
	output logic [63:0] key_low
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             adv;
	logic             in_take;
	acd_pkg::result_t res;
	acd_pkg::result_t res_q;
	logic             out_valid_q;

	// Parse the staged byte unless its result has nowhere to go
	assign adv      = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	acd_parse #(
		.MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (adv),
		.data_byte(byte_s1),
		.last     (last_s1),
		.result   (res)
	);

	// Result register: load at the last beat, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = res_q.action;
	assign led_number  = res_q.led_number;
	assign interval_ms = res_q.interval_ms;
	assign key_high    = res_q.key[127:64];
	assign key_low     = res_q.key[63:0];

	// A parsed last byte always lands in the result register
	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> out_valid_q)
		else $error("last beat did not produce a result");

	// Input stalls only behind a staged byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q))
		else $error("input stalled without a blocked result");

	// LED number is zero unless the action is a toggle
	a_led_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.action != acd_pkg::ACT_TOGGLE)) |-> (res_q.led_number == 4'd0))
		else $error("LED number set without toggle");

	// The interval is never zero
	a_ival_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.interval_ms != '0))
		else $error("zero interval reported");

endmodule

// ----- rtl/acd_parse.sv -----
// Per-byte parse state, command decision and the stored interval and key.
module acd_parse #(
	parameter int unsigned MAX_DATAGRAM_BYTES = 99
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              last,
	output acd_pkg::result_t  result
);

	localparam int unsigned PosW = $clog2(MAX_DATAGRAM_BYTES + 1);
	localparam logic [PosW-1:0] PosMax     = PosW'(MAX_DATAGRAM_BYTES);
	localparam logic [PosW-1:0] PosKeyEnd  = PosW'(acd_pkg::KEY_CHARS);
	localparam logic [PosW-1:0] PosKeyMin  = PosW'(acd_pkg::KEY_MIN_LEN);
	localparam logic [PosW-1:0] PosOne     = PosW'(1);

	logic [PosW-1:0]                pos_q, pos_n;
	acd_pkg::cmd_class_t            cls_q, cls_n;
	acd_pkg::shift_kind_t           shift_q, shift_n;
	logic [acd_pkg::ACC_W-1:0]      acc_q, acc_n;
	logic [acd_pkg::KEY_W-1:0]      kcol_q, kcol_n;
	logic                           hexok_q, hexok_n;
	logic [acd_pkg::KEY_W-1:0]      key_q, key_n;
	logic [acd_pkg::ACC_W-1:0]      ival_q, ival_n;

	logic [7:0]                     low_c;
	logic                           is_digit;
	logic                           is_hex;
	logic [3:0]                     nib;
	logic [acd_pkg::ACC_W+3:0]      prod;

	// Fold letters to lower case by setting bit 5 of every byte; digits already have it set
	assign low_c    = data_byte | 8'h20;
	assign is_digit = (data_byte >= "0") && (data_byte <= "9");

	// Hex character to nibble
	always_comb begin
		is_hex = 1'b1;
		nib    = 4'd0;
		if (is_digit) begin
			nib = 4'(data_byte - 8'h30);
		end else if ((low_c >= "a") && (low_c <= "f")) begin
			nib = 4'(low_c - 8'h57);
		end else begin
			is_hex = 1'b0;
		end
	end

	// acc * 10 + digit, wide enough not to wrap
	assign prod = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
		+ (acd_pkg::ACC_W+4)'(data_byte[3:0]);

	// Advance the parse state by one byte
	always_comb begin
		pos_n   = pos_q;
		cls_n   = cls_q;
		shift_n = shift_q;
		acc_n   = acc_q;
		kcol_n  = kcol_q;
		hexok_n = hexok_q;
		if (pos_q < PosMax) begin
			pos_n = pos_q + PosOne;
			if (pos_q == '0) begin
				priority if (low_c == "l") begin
					cls_n = acd_pkg::CLS_L;
				end else if (low_c == "d") begin
					cls_n = acd_pkg::CLS_D;
				end else if (low_c == "k") begin
					cls_n = acd_pkg::CLS_K;
				end else begin
					cls_n = acd_pkg::CLS_NONE;
				end
			end else begin
				if ((cls_q == acd_pkg::CLS_L) && (pos_q == PosOne)) begin
					if (low_c == "r") begin
						shift_n = acd_pkg::SHIFT_RIGHT;
					end else if (low_c == "l") begin
						shift_n = acd_pkg::SHIFT_LEFT;
					end
				end
				if (((cls_q == acd_pkg::CLS_L) || (cls_q == acd_pkg::CLS_D)) && is_digit) begin
					if (prod > {4'd0, acd_pkg::ACC_MAX}) begin
						acc_n = acd_pkg::ACC_MAX;
					end else begin
						acc_n = prod[acd_pkg::ACC_W-1:0];
					end
				end
				if ((cls_q == acd_pkg::CLS_K) && (pos_q <= PosKeyEnd)) begin
					if (is_hex) begin
						kcol_n = {kcol_q[acd_pkg::KEY_W-5:0], nib};
					end else begin
						hexok_n = 1'b0;
					end
				end
			end
		end
	end

	// Decide the action from the state after this byte
	always_comb begin
		result.action      = acd_pkg::ACT_NONE;
		result.led_number  = 4'd0;
		key_n              = key_q;
		ival_n             = ival_q;
		unique case (cls_n)
			acd_pkg::CLS_L: begin
				if (shift_n == acd_pkg::SHIFT_RIGHT) begin
					result.action = acd_pkg::ACT_SHR;
				end else if (shift_n == acd_pkg::SHIFT_LEFT) begin
					result.action = acd_pkg::ACT_SHL;
				end else if (acc_n <= acd_pkg::LED_MAX) begin
					result.action     = acd_pkg::ACT_TOGGLE;
					result.led_number = acc_n[3:0];
				end
			end
			acd_pkg::CLS_D: begin
				if (acc_n != '0) begin
					result.action = acd_pkg::ACT_INTERVAL;
					ival_n        = acc_n;
				end
			end
			acd_pkg::CLS_K: begin
				if ((pos_n >= PosKeyMin) && hexok_n) begin
					result.action = acd_pkg::ACT_KEY;
					key_n         = kcol_n;
				end
			end
			default: begin
			end
		endcase
		result.interval_ms = ival_n;
		result.key         = key_n;
	end

	// Hold state; clear the parse at the last beat and commit interval and key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			cls_q   <= acd_pkg::CLS_NONE;
			shift_q <= acd_pkg::SHIFT_NONE;
			acc_q   <= '0;
			kcol_q  <= '0;
			hexok_q <= 1'b1;
			key_q   <= acd_pkg::RESET_KEY;
			ival_q  <= acd_pkg::RESET_INTERVAL;
		end else if (take) begin
			if (last) begin
				pos_q   <= '0;
				cls_q   <= acd_pkg::CLS_NONE;
				shift_q <= acd_pkg::SHIFT_NONE;
				acc_q   <= '0;
				kcol_q  <= '0;
				hexok_q <= 1'b1;
				key_q   <= key_n;
				ival_q  <= ival_n;
			end else begin
				pos_q   <= pos_n;
				cls_q   <= cls_n;
				shift_q <= shift_n;
				acc_q   <= acc_n;
				kcol_q  <= kcol_n;
				hexok_q <= hexok_n;
			end
		end
	end

endmodule

// ----- tb/ascii_command_decoder_top_test.sv -----
// Self-checking testbench for the ASCII command decoder: directed and random datagrams.
module ascii_command_decoder_top_test;

	localparam int unsigned MAX_BYTES      = 99;
	localparam int unsigned RANDOM_BYTES   = 720;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES  = 8;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        last      = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [3:0]  led_number;
	logic [30:0] interval_ms;
	logic [63:0] key_high;
	logic [63:0] key_low;

	// Idle rates of the two sides, in percent
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct    = 0;

	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;

	// Datagram parse state and live settings of the decoder
	int unsigned           dg_pos;
	acd_pkg::cmd_class_t   dg_class;
	acd_pkg::shift_kind_t  dg_shift;
	logic [30:0]           dg_number;
	logic [127:0]          dg_key;
	bit                    dg_hex_ok;
	logic [127:0]          live_key;
	logic [30:0]           live_interval;

	acd_pkg::result_t      pending_results[$];
	logic [7:0]            frame[$];

	ascii_command_decoder_top #(
		.MAX_DATAGRAM_BYTES(MAX_BYTES)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action),
		.led_number (led_number),
		.interval_ms(interval_ms),
		.key_high   (key_high),
		.key_low    (key_low)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int hex_char_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function void clear_datagram();
		dg_pos    = 0;
		dg_class  = acd_pkg::CLS_NONE;
		dg_shift  = acd_pkg::SHIFT_NONE;
		dg_number = '0;
		dg_key    = '0;
		dg_hex_ok = 1'b1;
	endfunction

	// Advance the parse by one accepted beat; queue the decoded result on the last one
	function void decode_beat(input logic [7:0] b, input bit fin);
		acd_pkg::result_t r;
		logic [34:0]      wide;
		int               nib;
		if (dg_pos < MAX_BYTES) begin
			if (dg_pos == 0) begin
				case (b)
					"L", "l": dg_class = acd_pkg::CLS_L;
					"D", "d": dg_class = acd_pkg::CLS_D;
					"K", "k": dg_class = acd_pkg::CLS_K;
					default:  dg_class = acd_pkg::CLS_NONE;
				endcase
			end else begin
				if (dg_class == acd_pkg::CLS_L && dg_pos == 1) begin
					if (b == "R" || b == "r") dg_shift = acd_pkg::SHIFT_RIGHT;
					else if (b == "L" || b == "l") dg_shift = acd_pkg::SHIFT_LEFT;
				end
				// accumulate decimal digits, saturating
				if ((dg_class == acd_pkg::CLS_L || dg_class == acd_pkg::CLS_D)
						&& b >= "0" && b <= "9") begin
					wide = 35'(dg_number) * 35'd10 + 35'(b - "0");
					dg_number = (wide > 35'(acd_pkg::ACC_MAX)) ? acd_pkg::ACC_MAX
						: wide[30:0];
				end
				// shift in key nibbles from the first 32 key characters
				if (dg_class == acd_pkg::CLS_K && dg_pos <= acd_pkg::KEY_CHARS) begin
					nib = hex_char_value(b);
					if (nib < 0) dg_hex_ok = 1'b0;
					else dg_key = {dg_key[123:0], 4'(nib)};
				end
			end
			dg_pos++;
		end
		if (!fin) return;
		r.action     = acd_pkg::ACT_NONE;
		r.led_number = 4'd0;
		case (dg_class)
			acd_pkg::CLS_L: begin
				if (dg_shift == acd_pkg::SHIFT_RIGHT) r.action = acd_pkg::ACT_SHR;
				else if (dg_shift == acd_pkg::SHIFT_LEFT) r.action = acd_pkg::ACT_SHL;
				else if (dg_number <= acd_pkg::LED_MAX) begin
					r.action     = acd_pkg::ACT_TOGGLE;
					r.led_number = dg_number[3:0];
				end
			end
			acd_pkg::CLS_D: begin
				if (dg_number != '0) begin
					live_interval = dg_number;
					r.action      = acd_pkg::ACT_INTERVAL;
				end
			end
			acd_pkg::CLS_K: begin
				if (dg_pos >= acd_pkg::KEY_MIN_LEN && dg_hex_ok) begin
					live_key = dg_key;
					r.action = acd_pkg::ACT_KEY;
				end
			end
			default: ;
		endcase
		r.interval_ms = live_interval;
		r.key         = live_key;
		pending_results.push_back(r);
		clear_datagram();
	endfunction

	function void note_mismatch(input string what, input logic [127:0] want,
			input logic [127:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t on %s: expected %0h, got %0h", $time, what, want, got);
	endfunction

	// Drive receiver stalls and compare each accepted result beat
	always @(posedge clk) begin
		acd_pkg::result_t want;
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					note_mismatch("unexpected result", '0,
						128'({action, led_number, interval_ms}));
				end else begin
					want = pending_results.pop_front();
					if (action != want.action)
						note_mismatch("action", 128'(want.action), 128'(action));
					if (led_number != want.led_number)
						note_mismatch("led_number", 128'(want.led_number),
							128'(led_number));
					if (interval_ms != want.interval_ms)
						note_mismatch("interval_ms", 128'(want.interval_ms),
							128'(interval_ms));
					if (key_high != want.key[127:64])
						note_mismatch("key_high", 128'(want.key[127:64]), 128'(key_high));
					if (key_low != want.key[63:0])
						note_mismatch("key_low", 128'(want.key[63:0]), 128'(key_low));
				end
			end
		end
	end

	// End the run when nothing moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	task set_idling(input int unsigned gap, input int unsigned stall);
		send_gap_pct = gap;
		stall_pct    = stall;
	endtask

	// Send one byte beat, holding it until accepted
	task send_beat(input logic [7:0] b, input bit fin);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last      <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_beat(b, fin);
	endtask

	task send_frame();
		foreach (frame[i]) send_beat(frame[i], i == frame.size() - 1);
	endtask

	task send_text(input string s);
		frame.delete();
		for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
		send_frame();
	endtask

	// Hold the sender until every queued result has come back
	task drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task push_decimal(input longint unsigned n);
		string txt;
		txt = $sformatf("%0d", n);
		for (int i = 0; i < txt.len(); i++) frame.push_back(txt[i]);
	endtask

	task push_hex(input int unsigned v);
		if (v < 10) frame.push_back(8'("0" + v));
		else frame.push_back(8'(($urandom_range(1) ? "A" : "a") + v - 10));
	endtask

	task push_noise(input int unsigned count);
		repeat (count) frame.push_back(8'($urandom_range(255)));
	endtask

	task test_led_commands();
		set_idling(0, 0);
		send_text("L");
		send_text("l15");
		send_text("L16");
		send_text("Lx0y9");
		drain_results();
	endtask

	task test_shift_commands();
		set_idling(86, 0);
		send_text("LR");
		send_text("ll5");
		send_text("Lr99");
		drain_results();
	endtask

	task test_interval_commands();
		set_idling(0, 86);
		send_text("D1");
		send_text("d0");
		send_text("D");
		send_text("D2147483647");
		send_text("D99999999999");
		send_text("D 2a5");
		drain_results();
	endtask

	task test_key_commands();
		set_idling(23, 23);
		send_text("K0123456789abcdefABCDEF0123456789");
		send_text("K0123456789abcdefABCDEG0123456789");
		send_text("K0123456789abcdefABCDEF012345678");
		send_text("kFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF");
		send_text("k00000000000000000000000000000000zz");
		drain_results();
	endtask

	task test_unknown_and_overlong();
		set_idling(0, 0);
		send_text("X12");
		send_text("?");
		// digit at the last counted position lands, later ones are dropped
		frame.delete();
		frame.push_back("L");
		repeat (97) frame.push_back("x");
		frame.push_back("5");
		repeat (10) frame.push_back("7");
		send_frame();
		drain_results();
	endtask

	// Build one datagram, mostly well formed with random content
	task build_random_frame();
		int unsigned pick;
		int unsigned count;
		int unsigned bad_at;
		logic [7:0]  bad;
		frame.delete();
		pick = $urandom_range(99);
		if (pick < 20) begin
			frame.push_back($urandom_range(1) ? "L" : "l");
			if ($urandom_range(2) == 0) frame.push_back(" ");
			if ($urandom_range(3) != 0) push_decimal($urandom_range(20));
			push_noise($urandom_range(2));
		end else if (pick < 30) begin
			frame.push_back($urandom_range(1) ? "L" : "l");
			case ($urandom_range(3))
				0: frame.push_back("R");
				1: frame.push_back("r");
				2: frame.push_back("L");
				default: frame.push_back("l");
			endcase
			push_noise($urandom_range(3));
		end else if (pick < 50) begin
			frame.push_back($urandom_range(1) ? "D" : "d");
			if ($urandom_range(3) == 0) frame.push_back("=");
			case ($urandom_range(4))
				0: push_decimal(0);
				1: push_decimal($urandom_range(5000));
				2: push_decimal($urandom);
				3: push_decimal({$urandom, $urandom});
				default: ;
			endcase
			push_noise($urandom_range(2));
		end else if (pick < 70) begin
			frame.push_back($urandom_range(1) ? "K" : "k");
			repeat (acd_pkg::KEY_CHARS) push_hex($urandom_range(15));
			push_noise($urandom_range(3));
		end else if (pick < 78) begin
			frame.push_back($urandom_range(1) ? "K" : "k");
			count  = $urandom_range(1) ? acd_pkg::KEY_CHARS
				: $urandom_range(acd_pkg::KEY_CHARS - 1);
			bad_at = $urandom_range(acd_pkg::KEY_CHARS - 1);
			for (int i = 0; i < count; i++) begin
				if (count == acd_pkg::KEY_CHARS && i == bad_at) begin
					do bad = 8'($urandom_range(255)); while (hex_char_value(bad) >= 0);
					frame.push_back(bad);
				end else begin
					push_hex($urandom_range(15));
				end
			end
		end else if (pick < 98) begin
			push_noise(1 + $urandom_range(8));
		end else begin
			case ($urandom_range(2))
				0: frame.push_back("L");
				1: frame.push_back("D");
				default: frame.push_back("K");
			endcase
			count = $urandom_range(100, 127);
			repeat (count - 1) push_hex($urandom_range(15));
		end
	endtask

	task test_random_datagrams();
		int unsigned sent;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			case ((sent / 180) % 4)
				0: set_idling(0, 0);
				1: set_idling(86, 0);
				2: set_idling(0, 86);
				default: set_idling(23, 23);
			endcase
			build_random_frame();
			sent += frame.size();
			send_frame();
			if (sent >= RANDOM_BYTES / 2 && sent - frame.size() < RANDOM_BYTES / 2)
				drain_results();
		end
	endtask

	initial begin
		clear_datagram();
		live_key      = acd_pkg::RESET_KEY;
		live_interval = acd_pkg::RESET_INTERVAL;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_led_commands();
		test_shift_commands();
		test_interval_commands();
		test_key_commands();
		test_unknown_and_overlong();
		test_random_datagrams();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/acd_pkg.sv
rtl/acd_parse.sv
rtl/ascii_command_decoder_top.sv
tb/ascii_command_decoder_top_test.sv
